>>> hdl/spq_pkg.sv
// spq_pkg: shared types and constants of the sorted priority queue
// word layouts, opcode and status codes, cell control struct
// no dependencies
package spq_pkg;

  localparam int KEY_W       = 48;
  localparam int FIELD_W     = 16;
  localparam int CAP_W       = 5;
  localparam int ENTRY_CNT_W = 5;
  localparam int DEF_CAP     = 10;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CFG_ORDER_MODE = 1'b0,
    CFG_CAPACITY   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] item_time;
    logic [FIELD_W-1:0] item_arrival;
    logic [FIELD_W-1:0] item_pid;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [FIELD_W-1:0]     head_time;
    logic [FIELD_W-1:0]     head_arrival;
    logic [FIELD_W-1:0]     head_pid;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } out_word_t;

  // control broadcast to every cell
  typedef struct packed {
    logic ins;        // insert that goes ahead
    logic rem;        // remove of a held head
    logic low_first;  // smallest key at head
  } cell_ctrl_t;

endpackage

>>> hdl/spq_cell.sv
// spq_cell: one slot of the sorted queue, holds one key
// compares the incoming key, shifts right on insert and left on remove
// depends on spq_pkg
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  key_t       new_key,
  input  key_t       left_key,
  input  key_t       right_key,
  input  logic       slot_valid,
  input  logic       slot_tail,
  input  logic       found_in,
  output logic       found_out,
  output key_t       key_q
);

  key_t key_r;
  key_t key_nxt;
  logic ahead;
  logic take_here;

  // new key must stand ahead of this entry
  always_comb begin
    ahead     = ctrl.low_first ? (new_key < key_r) : (new_key > key_r);
    take_here = (slot_valid && ahead) || slot_tail;
    found_out = found_in || take_here;
  end

  // next slot content
  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (found_in) begin
        key_nxt = left_key;
      end else if (take_here) begin
        key_nxt = new_key;
      end
    end else if (ctrl.rem) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

>>> hdl/sorted_priority_queue.sv
// sorted_priority_queue: bounded priority queue kept sorted in a row of cells
// top level with count, capacity logic, config registers and output skid stage
// depends on spq_pkg and spq_cell
//
//   port group  | dir | flow control      | content
//   in_*        | in  | in_valid/in_stall | in_data: opcode and key fields
//   out_*       | out | out_valid/out_stall | out_data: status, head, count
//   cfg_*       | in  | cfg_we            | cfg_index, cfg_data
//
// one word per cycle while in_stall is low: every cell compares and shifts in
// the same cycle, the first-match flag ripples along the row of MAX_ENTRIES cells
// result is registered in out_data, or in the skid register if out_data stalls
// rst_n (synchronous) empties the queue, sets largest-first and capacity 10
// a second result is held in a skid register; in_stall rises only while it is full
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic             mode_r;
  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;
  out_word_t  skid_data_r, skid_data_nxt;

  logic       acc;
  logic       take;
  logic       full;
  logic       empty;
  logic       is_ins;
  logic       is_rem;
  logic [XW-1:0] eff_cap;
  key_t       new_key;
  out_word_t  res;
  cell_ctrl_t ctrl;

  key_t key_q [MAX_ENTRIES];
  logic found [MAX_ENTRIES+1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cap_r  <= CAP_W'(DEF_CAP);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORDER_MODE: mode_r <= cfg_data[0];
        CFG_CAPACITY:   cap_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // capacity in force, zero means default, saturate at the store size
  always_comb begin
    eff_cap = (cap_r == '0) ? XW'(DEF_CAP) : XW'(cap_r);
    if (eff_cap > XW'(MAX_ENTRIES)) begin
      eff_cap = XW'(MAX_ENTRIES);
    end
  end

  // handshake
  assign acc      = in_valid && !skid_valid_r;
  assign take     = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  // opcode decode
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (in_data.opcode)
      OP_INSERT: is_ins = 1'b1;
      OP_REMOVE: is_rem = 1'b1;
      default:   ;
    endcase
  end

  assign full    = XW'(cnt_r) >= eff_cap;
  assign empty   = (cnt_r == '0);
  assign new_key = {in_data.item_time, in_data.item_arrival, in_data.item_pid};

  always_comb begin
    ctrl.ins       = acc && is_ins && !full;
    ctrl.rem       = acc && is_rem && !empty;
    ctrl.low_first = mode_r;
  end

  // entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (ctrl.rem) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // row of cells, slot 0 is the head
  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    key_t left_key;
    key_t right_key;
    if (i == 0) begin : g_first
      assign left_key = new_key;
    end else begin : g_mid
      assign left_key = key_q[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_key = key_q[i];
    end else begin : g_inner
      assign right_key = key_q[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_key    (new_key),
      .left_key   (left_key),
      .right_key  (right_key),
      .slot_valid (CW'(i) < cnt_r),
      .slot_tail  (CW'(i) == cnt_r),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .key_q      (key_q[i])
    );
  end

  // result word of the accepted input
  always_comb begin
    res              = '0;
    res.entry_count  = ENTRY_CNT_W'(cnt_nxt);
    if (is_ins) begin
      res.status = full ? ST_FULL : ST_OK;
    end else if (empty) begin
      res.status = ST_EMPTY;
    end else begin
      res.status       = ST_OK;
      res.head_time    = key_q[0][KEY_W-1 -: FIELD_W];
      res.head_arrival = key_q[0][KEY_W-FIELD_W-1 -: FIELD_W];
      res.head_pid     = key_q[0][FIELD_W-1:0];
    end
  end

  // output register and skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (acc) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) <= XW'(MAX_ENTRIES))
    else $error("entry count above store size");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while output register empty");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("insert did not grow the count");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("remove did not shrink the count");

  a_no_dual_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove in the same cycle");

endmodule

>>> bench/spq_checker.sv
// spq_checker: watches the word channels and config port of the sorted priority queue
// keeps its own sorted copy of the queue, predicts each result word and compares it
// depends on spq_pkg
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_word_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_word_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CAP_W-1:0] cfg_data,
  output int               mismatch_count,
  output int               words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow queue, sorted with the head in slot 0
  key_t             held_keys [QUEUE_DEPTH];
  int               held_count;
  logic             low_first;
  logic [CAP_W-1:0] cap_reg;

  // result words waiting for the block to deliver them
  out_word_t expected_words [$];

  // strict ordering in the current mode; equal keys never pass each other
  function automatic bit goes_ahead(input key_t a, input key_t b);
    return low_first ? (a < b) : (a > b);
  endfunction

  // apply one word to the shadow queue and build the result it should give
  function automatic out_word_t predict_queue_op(input in_word_t w);
    out_word_t r;
    key_t      k;
    int        limit;
    int        slot;
    bit        found;
    r = '0;
    if (cap_reg == 0) limit = DEF_CAP;
    else if (cap_reg > QUEUE_DEPTH) limit = QUEUE_DEPTH;
    else limit = cap_reg;
    if (w.opcode == OP_INSERT) begin
      if (held_count >= limit) begin
        r.status = ST_FULL;
      end else begin
        k = {w.item_time, w.item_arrival, w.item_pid};
        slot = held_count;
        found = 1'b0;
        // first entry the new key must stand ahead of
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!found && i < held_count && goes_ahead(k, held_keys[i])) begin
            slot = i;
            found = 1'b1;
          end
        end
        for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
          if (i > slot && i <= held_count) held_keys[i] = held_keys[i-1];
        end
        held_keys[slot] = k;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // remove, peek and the spare code all report the head
      r.status       = ST_OK;
      r.head_time    = held_keys[0][47:32];
      r.head_arrival = held_keys[0][31:16];
      r.head_pid     = held_keys[0][15:0];
      if (w.opcode == OP_REMOVE) begin
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (i < held_count) held_keys[i-1] = held_keys[i];
        end
        held_count--;
      end
    end
    r.entry_count = held_count[ENTRY_CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // sample both channels and the config port at every edge
  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      held_count     = 0;
      low_first      = 1'b0;
      cap_reg        = CAP_W'(DEF_CAP);
      mismatch_count = 0;
      expected_words.delete();
      words_pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ORDER_MODE) low_first = cfg_data[0];
        else cap_reg = cfg_data;
      end
      // result accepted this edge: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0h count %0d",
                 out_data.status, out_data.entry_count);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("head_time", want.head_time, out_data.head_time);
          check_field("head_arrival", want.head_arrival, out_data.head_arrival);
          check_field("head_pid", want.head_pid, out_data.head_pid);
          check_field("entry_count", want.entry_count, out_data.entry_count);
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(predict_queue_op(in_data));
      words_pending <= expected_words.size();
    end
  end

endmodule

>>> bench/tb_top.sv
// tb_top: stimulus and verdict for the sorted priority queue
// drives words, config writes and output stalls; spq_checker does the predicting
// depends on spq_pkg, sorted_priority_queue and spq_checker
module tb_top
  import spq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 700;
  localparam int LONG_HOLD    = 64;
  localparam int CYCLE_LIMIT  = 400000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CAP_W-1:0] cfg_data;

  int fail_count;
  int words_pending;
  int cycle_count;
  bit idle_on;
  bit burst_req;

  sorted_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spq_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (fail_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // receiver: random stalls plus a long hold-off on request
  initial begin : receiver
    int run;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (burst_req) begin
        burst_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (run > 0) begin
        run--;
        out_stall <= 1'b1;
      end else begin
        run = idle_len();
        out_stall <= (run > 0);
        if (run > 0) run--;
      end
    end
  end

  // key fields lean toward small values and the top so ties and extremes show up
  function automatic logic [15:0] key_field();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom_range(0, 3));
    if (r < 4) return 16'hFFFF - 16'($urandom_range(0, 1));
    return 16'($urandom);
  endfunction

  function automatic in_word_t make_word(input opcode_t op, input logic [15:0] t,
                                         input logic [15:0] a, input logic [15:0] p);
    in_word_t w;
    w.opcode       = op;
    w.item_time    = t;
    w.item_arrival = a;
    w.item_pid     = p;
    return w;
  endfunction

  function automatic in_word_t random_word(input int insert_pct);
    opcode_t op;
    int      r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) op = OP_INSERT;
    else begin
      r = $urandom_range(0, 9);
      op = (r < 6) ? OP_REMOVE : ((r < 9) ? OP_PEEK : OP_SPARE);
    end
    return make_word(op, key_field(), key_field(), key_field());
  endfunction

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input in_word_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CAP_W-1:0] random_capacity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return CAP_W'(16);
    if (r < 40) return CAP_W'($urandom_range(17, 31));
    if (r < 55) return CAP_W'($urandom_range(1, 3));
    return CAP_W'($urandom_range(4, 15));
  endfunction

  initial begin : stimulus
    int sent;
    int phase;
    int phase_len;
    int insert_pct;
    logic [CAP_W-1:0] cap;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ORDER_MODE;
    cfg_data  <= '0;
    idle_on   = 1'b0;
    burst_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: largest first, capacity 10; empty queue first
    send_word(make_word(OP_PEEK, 16'h1234, 16'h5678, 16'h9abc));
    send_word(make_word(OP_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(OP_SPARE, 16'h0, 16'h0, 16'h0));
    send_word(make_word(OP_INSERT, 16'h0, 16'h0, 16'h0));
    send_word(make_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(OP_INSERT, 16'h5, 16'h1, 16'h9));
    send_word(make_word(OP_INSERT, 16'h5, 16'h1, 16'h9));
    send_word(make_word(OP_INSERT, 16'h5, 16'h0, 16'hFFFF));
    send_word(make_word(OP_PEEK, 16'h0, 16'h0, 16'h0));
    send_word(make_word(OP_SPARE, 16'hAAAA, 16'h5555, 16'hAAAA));
    repeat (6) send_word(make_word(OP_REMOVE, 16'h0, 16'h0, 16'h0));
    wait_drained();

    // smallest first with spare mode bits set, capacity of one
    write_reg(CFG_ORDER_MODE, 5'b11111);
    write_reg(CFG_CAPACITY, CAP_W'(1));
    send_word(make_word(OP_INSERT, 16'h7, 16'h3, 16'h1));
    send_word(make_word(OP_INSERT, 16'h1, 16'h0, 16'h0));
    send_word(make_word(OP_PEEK, 16'h0, 16'h0, 16'h0));
    send_word(make_word(OP_REMOVE, 16'h0, 16'h0, 16'h0));
    wait_drained();

    // random phases; the queue carries over, so capacity often drops below the fill
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0: begin
          cap = CAP_W'(16);
          insert_pct = 85;
        end
        1: begin
          cap = CAP_W'(2);
          insert_pct = 40;
        end
        2: begin
          cap = '0;
          insert_pct = 70;
        end
        3: begin
          cap = CAP_W'(31);
          insert_pct = 80;
        end
        default: begin
          cap = random_capacity();
          insert_pct = $urandom_range(20, 85);
        end
      endcase
      write_reg(CFG_ORDER_MODE, CAP_W'($urandom_range(0, 31)));
      write_reg(CFG_CAPACITY, cap);
      idle_on = ($urandom_range(0, 9) < 7);

      // back-pressure: receiver holds off while words keep coming
      if (phase == 2) begin
        idle_on   = 1'b0;
        burst_req = 1'b1;
        repeat (30) send_word(random_word(insert_pct));
        sent += 30;
        idle_on = 1'b1;
      end

      phase_len = $urandom_range(30, 70);
      repeat (phase_len) send_word(random_word(insert_pct));
      sent += phase_len;
      wait_drained();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
